// File: sv/dsw_pkg.sv
// Shared types and constants for the dithered sample widener.
`timescale 1ns / 1ps

package dsw_pkg;

  localparam int unsigned SampleW = 32;
  localparam int unsigned ResultW = 33;
  localparam int unsigned BitsW   = 6;
  localparam int unsigned NoiseW  = 24;
  localparam int unsigned GainSh  = 7;  // unity gain of 128

  localparam logic [BitsW-1:0]  BitsMin   = 6'd8;
  localparam logic [BitsW-1:0]  BitsFull  = 6'd32;
  localparam logic [BitsW-1:0]  BitsReset = 6'd16;

  localparam logic [NoiseW-1:0] NoiseTaps  = 24'hFFFF1D;
  localparam logic [NoiseW-1:0] NoiseTop   = 24'h800000;
  localparam logic [NoiseW-1:0] NoiseReset = 24'h000001;

  // One accepted sample held between the input and result registers
  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic [BitsW-1:0]          bits;
    logic [NoiseW-1:0]         noise;
    logic                      dither_en;
  } stage_t;

endpackage

// File: sv/dsw_if.sv
// Valid/ready channel interfaces for samples in and widened samples out.
`timescale 1ns / 1ps

interface dsw_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [dsw_pkg::SampleW-1:0]       sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface dsw_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [dsw_pkg::ResultW-1:0]       sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// File: sv/dithered_sample_widener.sv
// Dithered sample widener: widens signed samples to 32-bit full scale with LFSR dither.
`timescale 1ns / 1ps

// Takes one signed sample per beat, keeps its low sample_bits bits (clamped to
// 8..32), sign-extends and scales it to 32-bit full scale, and below 32 bits adds
// dither from a 24-bit Galois LFSR that steps once per dithered sample. The block
// sustains one sample per clock while the sink takes each result: an input register
// and a result register form a two-stage pipeline that each sample passes through
// before it is presented. Each stage advances whenever the one after it
// has room, so an empty result register is refilled even while the sink stalls,
// and two samples can wait inside before the input stalls. The LFSR steps at input
// acceptance. Write sample_bits only while no samples are in flight.
module dithered_sample_widener (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dsw_pkg::BitsW-1:0]      cfg_wdata,
  dsw_in_if.sink                         din,
  dsw_out_if.source                      dout
);

  logic [dsw_pkg::BitsW-1:0]  sample_bits;
  logic [dsw_pkg::BitsW-1:0]  eff_bits;
  logic                       dither_en;
  logic [dsw_pkg::NoiseW-1:0] lfsr;
  logic [dsw_pkg::NoiseW-1:0] lfsr_next;
  logic [dsw_pkg::NoiseW:0]   lfsr_sum;
  logic                       in_beat;

  dsw_pkg::stage_t            stage;
  logic                       stage_valid;
  logic                       stage_ready;
  logic                       out_ready;

  logic [4:0]                 left_sh;
  logic [4:0]                 right_sh;
  logic signed [31:0]         widened;
  logic [dsw_pkg::NoiseW-1:0] noise_flip;
  logic signed [30:0]         noise_scaled;
  logic signed [30:0]         dither;
  logic signed [dsw_pkg::ResultW-1:0] result_next;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_bits <= dsw_pkg::BitsReset;
    end else if (cfg_we) begin
      sample_bits <= cfg_wdata;
    end
  end

  // Clamp the width into 8..32
  always_comb begin
    if (sample_bits < dsw_pkg::BitsMin) begin
      eff_bits = dsw_pkg::BitsMin;
    end else if (sample_bits > dsw_pkg::BitsFull) begin
      eff_bits = dsw_pkg::BitsFull;
    end else begin
      eff_bits = sample_bits;
    end
  end
  assign dither_en = (eff_bits != dsw_pkg::BitsFull);

  // Handshake: each stage advances when the one after it has room
  assign out_ready   = !dout.valid || dout.ready;
  assign stage_ready = !stage_valid || out_ready;
  assign din.ready   = stage_ready;
  assign in_beat     = din.valid && din.ready;

  // Galois LFSR step: add taps on odd state, then halve
  always_comb begin
    lfsr_sum = {1'b0, lfsr};
    if (lfsr[0]) begin
      lfsr_sum = {1'b0, lfsr} + {1'b0, dsw_pkg::NoiseTaps};
    end
    lfsr_next = lfsr_sum[dsw_pkg::NoiseW:1];
  end

  // Advance the LFSR once per dithered beat
  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= dsw_pkg::NoiseReset;
    end else if (in_beat && dither_en) begin
      lfsr <= lfsr_next;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (stage_ready) begin
      stage_valid <= din.valid;
    end
    if (in_beat) begin
      stage.sample    <= din.sample_in;
      stage.bits      <= eff_bits;
      stage.noise     <= lfsr_next;
      stage.dither_en <= dither_en;
    end
  end

  // Widen the sample and build the dither term
  always_comb begin
    left_sh      = 5'(dsw_pkg::BitsFull - stage.bits);
    right_sh     = 5'(stage.bits - 6'd2);
    widened      = stage.sample <<< left_sh;
    noise_flip   = stage.noise ^ dsw_pkg::NoiseTop;
    noise_scaled = {noise_flip, {dsw_pkg::GainSh{1'b0}}};
    dither       = noise_scaled >>> right_sh;
    result_next  = 33'(widened);
    if (stage.dither_en) begin
      result_next = 33'(widened) + 33'(dither);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (out_ready) begin
      dout.valid <= stage_valid;
    end
    if (out_ready && stage_valid) begin
      dout.sample_out <= result_next;
    end
  end

`ifndef SYNTH
  // The LFSR never falls into the all-zero lockup state
  a_lfsr_nonzero: assert property (@(posedge clk) disable iff (rst)
    lfsr != '0)
    else $error("noise LFSR reached zero");

  // The LFSR holds unless a dithered beat is taken
  a_lfsr_hold: assert property (@(posedge clk) disable iff (rst)
    !(in_beat && dither_en) |=> $stable(lfsr))
    else $error("noise LFSR stepped without a dithered beat");

  // A held sample moves into the result register when there is room
  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    stage_valid && out_ready |=> dout.valid)
    else $error("held sample lost between stages");

  // Captured width stays clamped
  a_bits_range: assert property (@(posedge clk) disable iff (rst)
    stage_valid |-> (stage.bits >= dsw_pkg::BitsMin && stage.bits <= dsw_pkg::BitsFull))
    else $error("captured width out of range");
`endif

endmodule

// File: bench/dsw_checker.sv
// Result checker for the dithered sample widener: predicts each widened sample and compares.
`timescale 1ns / 1ps

module dsw_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [dsw_pkg::BitsW-1:0] cfg_wdata,
  dsw_in_if                         din,
  dsw_out_if                        dout,
  output int                        fail_count,
  output int                        outstanding
);

  logic [dsw_pkg::NoiseW-1:0]  lfsr_q;
  logic [dsw_pkg::BitsW-1:0]   width_q;
  logic [dsw_pkg::ResultW-1:0] expected_samples[$];
  logic [dsw_pkg::ResultW-1:0] want;

  // Widen one sample at the current width; step the noise LFSR when dithering
  function automatic logic [dsw_pkg::ResultW-1:0] widen_and_dither(
    logic [dsw_pkg::SampleW-1:0] raw);
    int                         eff;
    longint                     acc;
    longint                     noise_term;
    logic [dsw_pkg::NoiseW:0]   sum;
    logic [dsw_pkg::NoiseW-1:0] flipped;
    eff = int'((width_q < dsw_pkg::BitsMin) ? dsw_pkg::BitsMin :
               (width_q > dsw_pkg::BitsFull) ? dsw_pkg::BitsFull : width_q);
    // Sign-extend the low eff bits, then scale up to 32-bit full scale
    acc = {32'd0, raw};
    acc = (acc <<< (64 - eff)) >>> (64 - eff);
    acc = acc <<< (32 - eff);
    if (eff < dsw_pkg::BitsFull) begin
      // Galois step: add the taps when the low bit is set, then halve
      sum = {1'b0, lfsr_q} + (lfsr_q[0] ? {1'b0, dsw_pkg::NoiseTaps} : '0);
      lfsr_q = sum[dsw_pkg::NoiseW:1];
      // Flip the top bit, sign-extend, apply unity gain, floor shift to the sample's LSB
      flipped = lfsr_q ^ dsw_pkg::NoiseTop;
      noise_term = {{(64 - dsw_pkg::NoiseW){flipped[dsw_pkg::NoiseW-1]}}, flipped};
      acc = acc + ((noise_term <<< dsw_pkg::GainSh) >>> (eff - 2));
    end
    return acc[dsw_pkg::ResultW-1:0];
  endfunction

  // Track config, predict on every input beat, compare on every output beat
  always @(posedge clk) begin
    if (rst) begin
      lfsr_q     = dsw_pkg::NoiseReset;
      width_q    = dsw_pkg::BitsReset;
      fail_count = 0;
      expected_samples.delete();
    end else begin
      if (dout.valid && dout.ready) begin
        if (expected_samples.size() == 0) begin
          $error("sample_out beat with no sample pending: actual %h", dout.sample_out);
          fail_count = fail_count + 1;
        end else begin
          want = expected_samples.pop_front();
          if (dout.sample_out !== want) begin
            $error("sample_out mismatch: expected %h actual %h", want, dout.sample_out);
            fail_count = fail_count + 1;
          end
        end
      end
      if (din.valid && din.ready)
        expected_samples.push_back(widen_and_dither(din.sample_in));
      if (cfg_we)
        width_q = cfg_wdata;
    end
    outstanding = expected_samples.size();
  end

endmodule

// File: bench/tb_dithered_sample_widener.sv
// Testbench top for the dithered sample widener: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_dithered_sample_widener;

  localparam int ResetCycles = 4;
  localparam int IdleLimit   = 2000;
  localparam int LongHold    = 300;
  localparam int RandPhases  = 12;
  localparam int PhaseItems  = 60;
  localparam int SettleCycles = 6;
  localparam logic [dsw_pkg::BitsW-1:0] CornerWidths [4] = '{6'd8, 6'd32, 6'd9, 6'd31};

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      cfg_we    = 1'b0;
  logic [dsw_pkg::BitsW-1:0] cfg_wdata = '0;
  logic                      hold_req  = 1'b0;
  logic                      hold_done = 1'b0;
  int                        cur_w     = 16;
  int                        idle_cycles = 0;
  int                        fail_count;
  int                        outstanding;

  dsw_in_if  din();
  dsw_out_if dout();

  dithered_sample_widener uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .din       (din),
    .dout      (dout)
  );

  dsw_checker widen_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .din         (din),
    .dout        (dout),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // End the run if no beat moves for too long
  always @(posedge clk) begin
    if (rst || (din.valid && din.ready) || (dout.valid && dout.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("dithered_sample_widener regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Pick a sample that stresses the edges of the active width, junk above it
  function automatic logic [dsw_pkg::SampleW-1:0] pick_sample(int w);
    logic [63:0]                 m;
    logic [dsw_pkg::SampleW-1:0] junk;
    m = (64'd1 << w) - 1;
    junk = $urandom & ~m[dsw_pkg::SampleW-1:0];
    case ($urandom_range(0, 7))
      0: return junk | (m[dsw_pkg::SampleW-1:0] >> 1);
      1: return junk | (32'd1 << (w - 1));
      2: return junk | m[dsw_pkg::SampleW-1:0];
      3: return junk;
      4: return junk | $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  // Offer one sample and hold it until it is taken
  task automatic send_beat(logic [dsw_pkg::SampleW-1:0] v);
    @(negedge clk);
    din.valid     <= 1'b1;
    din.sample_in <= v;
    do @(posedge clk); while (!din.ready);
  endtask

  // Drop valid and drive random data on sample_in during the pause
  task automatic pause_sender(int n);
    @(negedge clk);
    din.valid     <= 1'b0;
    din.sample_in <= $urandom;
    repeat (n - 1) @(negedge clk);
  endtask

  // Stop sending and wait until every predicted sample has come out
  task automatic drain();
    pause_sender(1);
    while (outstanding != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Write the width register with the pipeline empty
  task automatic write_width(logic [dsw_pkg::BitsW-1:0] v);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_w = int'((v < dsw_pkg::BitsMin) ? dsw_pkg::BitsMin :
                 (v > dsw_pkg::BitsFull) ? dsw_pkg::BitsFull : v);
  endtask

  // Send n samples in bursts of random length with random gaps
  task automatic send_run(int n);
    int left;
    int burst;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 16);
      if (burst > left)
        burst = left;
      repeat (burst) send_beat(pick_sample(cur_w));
      left -= burst;
      if ($urandom_range(0, 3) != 0)
        pause_sender($urandom_range(1, 12));
    end
  endtask

  // Receiver: segments of steady, random, mostly stalled and mostly open ready, plus one long hold
  initial begin : receiver
    int seg_len;
    int mode;
    dout.ready = 1'b0;
    forever begin
      if (hold_req && !hold_done) begin
        @(negedge clk);
        dout.ready <= 1'b0;
        repeat (LongHold) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        mode    = $urandom_range(0, 3);
        seg_len = $urandom_range(4, 60);
        for (int k = 0; k < seg_len && !(hold_req && !hold_done); k++) begin
          @(negedge clk);
          case (mode)
            0: dout.ready <= 1'b1;
            1: dout.ready <= 1'($urandom_range(0, 1));
            2: dout.ready <= ($urandom_range(0, 3) == 0);
            default: dout.ready <= ($urandom_range(0, 7) != 0);
          endcase
        end
      end
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    din.valid     = 1'b0;
    din.sample_in = '0;
    repeat (ResetCycles) @(negedge clk);
    rst <= 1'b0;

    // Reset width of 16: extremes, and junk above the sample ignored
    send_beat(32'h0000_7FFF);
    send_beat(32'h0000_8000);
    send_beat(32'hFFFF_FFFF);
    send_beat(32'h0000_0000);
    send_beat(32'hABCD_7FFF);
    send_beat(32'h7FFF_8000);
    // Narrowest width
    write_width(6'd8);
    send_beat(32'h0000_007F);
    send_beat(32'h0000_0080);
    send_beat(32'hFFFF_FF55);
    // Full width: no dither, LFSR holds
    write_width(6'd32);
    send_beat(32'h7FFF_FFFF);
    send_beat(32'h8000_0000);
    send_beat(32'hFFFF_FFFF);
    send_beat(32'h0000_0001);
    // Width below range clamps to 8
    write_width(6'd0);
    send_beat(32'h0000_007F);
    send_beat(32'h0000_0180);
    write_width(6'd7);
    send_beat(32'h0000_00FF);
    // One below full width
    write_width(6'd31);
    send_beat(32'h3FFF_FFFF);
    send_beat(32'h4000_0000);
    send_beat(32'hBFFF_FFFF);
    // Width above range clamps to 32
    write_width(6'd33);
    send_beat(32'h1234_5678);
    write_width(6'd63);
    send_beat(32'h8000_0000);
    write_width(6'd9);
    send_beat(32'h0000_0100);
    send_beat(32'h0000_00FF);

    // Random phases, each at its own width
    for (int p = 0; p < RandPhases; p++) begin
      if (p < 4)
        write_width(CornerWidths[p]);
      else if ($urandom_range(0, 4) == 0)
        write_width(6'($urandom_range(0, 63)));
      else
        write_width(6'($urandom_range(8, 32)));
      if (p == 2) begin
        // Keep offering while the receiver holds off, so the input stalls
        hold_req <= 1'b1;
        repeat (30) send_beat(pick_sample(cur_w));
        hold_req <= 1'b0;
      end
      send_run(PhaseItems);
    end

    drain();
    if (fail_count == 0)
      $display("dithered_sample_widener regression: pass");
    else
      $display("dithered_sample_widener regression: fail");
    $finish;
  end

endmodule

// File: dithered_sample_widener.f
sv/dsw_pkg.sv
sv/dsw_if.sv
sv/dithered_sample_widener.sv
bench/dsw_checker.sv
bench/tb_dithered_sample_widener.sv
